// ----- hdl/vbcr_pkg.sv -----
// Shared types and constants for the voxel box collision resolver.
// Depends on nothing; imported by the axis lane and the top level.
package vbcr_pkg;

    // Width of one box extent register.
    localparam int SIZE_W = 21;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Reset value of every size register: 1.0 in UQ5.16.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd65536;

    // Status that one axis lane reports to the top level.
    typedef struct packed {
        logic ov;    // unmoved box overlaps the voxel on this axis
        logic hit;   // move on this axis is clipped by the voxel
        logic down;  // running move on this axis is negative
    } t_axis_flags;

endpackage

// ----- hdl/vbcr_axis_lane.sv -----
// One axis of the collision resolver: holds the box bounds, running move and
// moved corner for that axis and computes overlap and clipping for a voxel.
// Depends on vbcr_pkg.
module vbcr_axis_lane #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_test,
    input  logic                               i_clip_en,
    input  logic signed [COORD_WIDTH-1:0]      i_coord,
    input  logic signed [COORD_WIDTH-1:0]      i_move,
    input  logic        [vbcr_pkg::SIZE_W-1:0] i_size,
    output vbcr_pkg::t_axis_flags              o_flags,
    output logic signed [COORD_WIDTH-1:0]      o_pos_next
);
    import vbcr_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int XW = COORD_WIDTH + 3;

    localparam logic signed [XW-1:0] UNIT_X =
        {{(XW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [XW-1:0] CMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] CMIN_X = ~CMAX_X;

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > CMAX_X) begin
            r = CMAX_X[W-1:0];
        end else if (v < CMIN_X) begin
            r = CMIN_X[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0]      r_lo;
    logic signed [W:0]        r_hi;
    logic signed [W-1:0]      r_move;
    logic signed [W-1:0]      r_pos;
    logic        [SIZE_W-1:0] r_size;

    logic signed [XW-1:0] c_x, lo_x, hi_x, m_x, vmax_x, size_x;
    logic signed [XW-1:0] lom_x, him_x, d_x, pos_in_x, hi_sat_x, lo_sat_x;
    logic signed [XW-1:0] start_sum_x, new_hi_x;
    logic                 neg, hit;
    logic signed [W-1:0]  clip_move, clip_pos;

    assign c_x    = XW'(i_coord);
    assign lo_x   = XW'(r_lo);
    assign hi_x   = XW'(r_hi);
    assign m_x    = XW'(r_move);
    assign size_x = XW'(r_size);
    assign vmax_x = c_x + UNIT_X;
    assign neg    = r_move[W-1];

    assign lom_x = lo_x + m_x;
    assign him_x = hi_x + m_x;
    assign hit   = i_test && i_clip_en && (r_move != '0) && (lom_x < vmax_x) && (him_x > c_x);

    // Clipped move: meet the voxel top face when moving down, else its low face.
    assign d_x = neg ? (vmax_x - lo_x) : (c_x - hi_x);

    // Moved corner after a clip, formed in parallel with the clipped move so that
    // only one add stands before each saturation.
    assign pos_in_x = neg ? vmax_x : (c_x - size_x);
    assign hi_sat_x = lo_x + CMAX_X;
    assign lo_sat_x = lo_x + CMIN_X;

    always_comb begin
        clip_move = sat(d_x);
        if (d_x > CMAX_X) begin
            clip_pos = sat(hi_sat_x);
        end else if (d_x < CMIN_X) begin
            clip_pos = sat(lo_sat_x);
        end else begin
            clip_pos = sat(pos_in_x);
        end
    end

    assign start_sum_x = c_x + XW'(i_move);
    assign new_hi_x    = c_x + XW'(i_size);

    always_comb begin
        if (i_load) begin
            o_pos_next = sat(start_sum_x);
        end else if (hit) begin
            o_pos_next = clip_pos;
        end else begin
            o_pos_next = r_pos;
        end
    end

    assign o_flags.ov   = (lo_x < vmax_x) && (hi_x > c_x);
    assign o_flags.hit  = hit;
    assign o_flags.down = neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= '0;
            r_hi   <= '0;
            r_move <= '0;
            r_pos  <= '0;
            r_size <= '0;
        end else begin
            if (i_load) begin
                r_lo   <= i_coord;
                r_hi   <= new_hi_x[W:0];
                r_move <= i_move;
                r_size <= i_size;
            end else if (hit) begin
                r_move <= clip_move;
            end
            r_pos <= o_pos_next;
        end
    end

endmodule

// ----- hdl/voxel_box_collision_resolver.sv -----
// Top level of the voxel box collision resolver: stream handshake, size
// registers, stop and landed flags and a two-entry result buffer.
// Depends on vbcr_pkg and vbcr_axis_lane.
//
//  Channel   Ports                  Dir  Beat carries
//  ------    ---------------------  ---  ---------------------------------------------
//  input     i_s_axis_* / o_s_*     in   coords, moves, solid; tuser action; tlast last
//  result    o_m_axis_* / i_m_*     out  new corner, stop flags, landed
//  config    psel..prdata, pready   in   size_x, size_y, size_z at 0x0, 0x4, 0x8
//
// The three axis lanes check a voxel in parallel, and the result of a last voxel is
// registered in the result register, or in the skid entry while that one is stalled.
// A new beat is accepted every cycle while the skid entry of the result buffer
// is empty, so one stalled result does not hold up the input side.
// Reset is synchronous and clears the box, the move, the flags and the buffer;
// the size registers return to 1.0.
module voxel_box_collision_resolver #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream.
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata from bit 0: coord_x, coord_y, coord_z, move_x, move_y, move_z, solid.
    input  logic [((6*COORD_WIDTH+1+7)/8)*8-1:0]   i_s_axis_tdata,
    // tuser: action (0 start an entity, 1 test a voxel).
    input  logic [0:0]                             i_s_axis_tuser,
    input  logic                                   i_s_axis_tlast,
    // Result stream.
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tdata from bit 0: new_x, new_y, new_z, stop_x, stop_y, stop_z, landed.
    output logic [((3*COORD_WIDTH+4+7)/8)*8-1:0]   o_m_axis_tdata,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [vbcr_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [vbcr_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [vbcr_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import vbcr_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = ((3*COORD_WIDTH+4+7)/8)*8;

    // 1.0 in the configured number format, cut to the register width.
    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access cycle; an index
    // past the last register is dropped and reads back as zero.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]    r_size_x, r_size_y, r_size_z;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_ONE;
            r_size_y <= SIZE_ONE;
            r_size_z <= SIZE_ONE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SIZE_X: r_size_x <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y: r_size_y <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z: r_size_z <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SIZE_X: prdata = APB_DATA_W'(r_size_x);
            REG_SIZE_Y: prdata = APB_DATA_W'(r_size_y);
            REG_SIZE_Z: prdata = APB_DATA_W'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode.
    // ------------------------------------------------------------------
    logic                s_accept, load, test, emit;
    logic signed [W-1:0] c_x, c_y, c_z, mv_x, mv_y, mv_z;
    logic                solid;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign c_x   = i_s_axis_tdata[W-1:0];
    assign c_y   = i_s_axis_tdata[2*W-1:W];
    assign c_z   = i_s_axis_tdata[3*W-1:2*W];
    assign mv_x  = i_s_axis_tdata[4*W-1:3*W];
    assign mv_y  = i_s_axis_tdata[5*W-1:4*W];
    assign mv_z  = i_s_axis_tdata[6*W-1:5*W];
    assign solid = i_s_axis_tdata[6*W];

    // A start beat loads the entity; a solid voxel beat is tested; a voxel
    // beat with tlast set produces one result.
    assign load = s_accept && !i_s_axis_tuser[0];
    assign test = s_accept && i_s_axis_tuser[0] && solid;
    assign emit = s_accept && i_s_axis_tuser[0] && i_s_axis_tlast;

    // ------------------------------------------------------------------
    // Axis lanes. Each axis is clipped only when the unmoved box overlaps
    // the voxel on both other axes; the axes do not interact otherwise.
    // ------------------------------------------------------------------
    t_axis_flags         fl_x, fl_y, fl_z;
    logic signed [W-1:0] pos_x, pos_y, pos_z;

    vbcr_axis_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_test     (test),
        .i_clip_en  (fl_y.ov && fl_z.ov),
        .i_coord    (c_x),
        .i_move     (mv_x),
        .i_size     (r_size_x),
        .o_flags    (fl_x),
        .o_pos_next (pos_x)
    );

    vbcr_axis_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_test     (test),
        .i_clip_en  (fl_x.ov && fl_z.ov),
        .i_coord    (c_y),
        .i_move     (mv_y),
        .i_size     (r_size_y),
        .o_flags    (fl_y),
        .o_pos_next (pos_y)
    );

    vbcr_axis_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_test     (test),
        .i_clip_en  (fl_x.ov && fl_y.ov),
        .i_coord    (c_z),
        .i_move     (mv_z),
        .i_size     (r_size_z),
        .o_flags    (fl_z),
        .o_pos_next (pos_z)
    );

    // ------------------------------------------------------------------
    // Stop and landed flags. A start beat clears them; a clip sets them.
    // The hit flags are already gated by the test strobe inside the lanes.
    // ------------------------------------------------------------------
    logic [2:0] r_stop, n_stop;
    logic       r_landed, n_landed;

    always_comb begin
        if (load) begin
            n_stop   = '0;
            n_landed = 1'b0;
        end else begin
            n_stop   = r_stop | {fl_z.hit, fl_y.hit, fl_x.hit};
            n_landed = r_landed | (fl_y.hit && fl_y.down);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop   <= '0;
            r_landed <= 1'b0;
        end else begin
            r_stop   <= n_stop;
            r_landed <= n_landed;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: an output register plus one skid entry. The input side
    // stalls only when both are full.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] n_res;
    logic [OUT_W-1:0] r_out_data, r_skid_data;
    logic             r_out_valid, r_skid_valid;
    logic             out_free;

    assign n_res = OUT_W'({n_landed, n_stop, pos_z, pos_y, pos_x});

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= emit;
            end
        end else if (emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (emit) begin
                r_out_data <= n_res;
            end
        end else if (emit) begin
            r_skid_data <= n_res;
        end
    end

endmodule

// ----- hdl/vbcr_checker.sv -----
// Port-level checks for the voxel box collision resolver, attached by bind.
// Depends only on the top level's ports.
module vbcr_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic [0:0]                           i_s_axis_tuser,
    input logic                                 i_s_axis_tlast,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((3*COORD_WIDTH+4+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int W = COORD_WIDTH;

    logic emit_beat;
    assign emit_beat = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] && i_s_axis_tlast;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // The input stalls only while a result is waiting.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with an empty result buffer");

    // With the buffer empty, only a last voxel beat brings up a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && !emit_beat |=> !o_m_axis_tvalid)
        else $error("result appeared without a last voxel beat");

    // With the buffer empty, a last voxel beat shows its result next cycle.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && emit_beat |=> o_m_axis_tvalid)
        else $error("last voxel beat gave no result");

    // Landing is a clip on Y, so it always comes with the Y stop flag.
    a_landed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3*W+3] |-> o_m_axis_tdata[3*W+1])
        else $error("landed without a Y stop");

endmodule

bind voxel_box_collision_resolver vbcr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

// ----- verif/tb_voxel_box_collision_resolver.sv -----
// Self-checking testbench for voxel_box_collision_resolver: drives entity and voxel beats,
// predicts each clipped move in SystemVerilog and compares every result beat.
// Depends on vbcr_pkg and the resolver RTL; needs no other file.
module tb_voxel_box_collision_resolver;
    import vbcr_pkg::*;

    localparam int     CW          = 32;
    localparam int     IN_W        = ((6*CW+1+7)/8)*8;
    localparam int     OUT_W       = ((3*CW+4+7)/8)*8;
    localparam longint ONE         = 64'sd65536;
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;
    // Idle tail that covers the result buffer before a size register is touched.
    localparam int     TAIL_CYCLES = 4;
    localparam int     DRAIN_LIMIT = 5000;
    localparam int     RANDOM_BEATS = 900;

    // tuser codes of the input stream.
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_VOXEL = 1'b1
    } t_action;

    // Layout of the input tdata, first member in the highest bits.
    typedef struct packed {
        logic          solid;
        logic [CW-1:0] move_z;
        logic [CW-1:0] move_y;
        logic [CW-1:0] move_x;
        logic [CW-1:0] coord_z;
        logic [CW-1:0] coord_y;
        logic [CW-1:0] coord_x;
    } t_beat_data;

    typedef struct packed {
        t_action    action;
        logic       last;
        t_beat_data d;
    } t_beat;

    // Layout of the result tdata below the padding bits.
    typedef struct packed {
        logic          landed;
        logic          stop_z;
        logic          stop_y;
        logic          stop_x;
        logic [CW-1:0] new_z;
        logic [CW-1:0] new_y;
        logic [CW-1:0] new_x;
    } t_move_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic [0:0]       i_s_axis_tuser;
    logic             i_s_axis_tlast;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b1;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic             pready;

    // Mirror of the block: box corners, clipped move, flags and size registers.
    longint           ent_low [3];
    longint           ent_high[3];
    longint           clipped_move[3];
    bit [2:0]         stop_bits;
    bit               landed_bit;
    logic [SIZE_W-1:0] size_q16[3];

    t_move_result     resolved_q[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int beats_sent     = 0;
    int work_beats     = 0;
    int size_settings  = 0;
    int stall_left     = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;

    voxel_box_collision_resolver i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint sext(input logic [CW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic string result_text(input t_move_result r);
        return $sformatf("new=(%h %h %h) stop=%b%b%b landed=%b", r.new_x, r.new_y, r.new_z,
                         r.stop_x, r.stop_y, r.stop_z, r.landed);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic reset_mirror();
        for (int a = 0; a < 3; a++) begin
            size_q16[a]     = SIZE_RESET;
            ent_low[a]      = 0;
            ent_high[a]     = 0;
            clipped_move[a] = 0;
        end
        stop_bits  = '0;
        landed_bit = 1'b0;
    endtask

    // Clip one axis of the move against a voxel spanning [vmin, vmax) on that axis.
    task automatic clip_axis(input int axis, input longint vmin, input longint vmax);
        longint m;
        m = clipped_move[axis];
        if (m != 0 && ent_low[axis] + m < vmax && ent_high[axis] + m > vmin) begin
            if (m < 0) begin
                clipped_move[axis] = clamp_coord(vmax - ent_low[axis]);
                if (axis == 1) landed_bit = 1'b1;
            end else begin
                clipped_move[axis] = clamp_coord(vmin - ent_high[axis]);
            end
            stop_bits[axis] = 1'b1;
        end
    endtask

    // Apply one accepted beat to the mirror; a last voxel queues the resolved move.
    task automatic resolve_beat(input t_beat b);
        longint       c[3];
        longint       mv[3];
        longint       vmin[3];
        longint       vmax[3];
        longint       p[3];
        bit           ov[3];
        t_move_result r;
        c[0]  = sext(b.d.coord_x);
        c[1]  = sext(b.d.coord_y);
        c[2]  = sext(b.d.coord_z);
        mv[0] = sext(b.d.move_x);
        mv[1] = sext(b.d.move_y);
        mv[2] = sext(b.d.move_z);
        if (b.action == ACT_START) begin
            for (int a = 0; a < 3; a++) begin
                ent_low[a]      = c[a];
                ent_high[a]     = c[a] + longint'(size_q16[a]);
                clipped_move[a] = mv[a];
            end
            stop_bits  = '0;
            landed_bit = 1'b0;
            return;
        end
        if (b.d.solid) begin
            for (int a = 0; a < 3; a++) begin
                vmin[a] = c[a];
                vmax[a] = c[a] + ONE;
                ov[a]   = ent_low[a] < vmax[a] && ent_high[a] > vmin[a];
            end
            // Y first, then X, then Z, each against the unmoved box.
            if (ov[0] && ov[2]) clip_axis(1, vmin[1], vmax[1]);
            if (ov[1] && ov[2]) clip_axis(0, vmin[0], vmax[0]);
            if (ov[0] && ov[1]) clip_axis(2, vmin[2], vmax[2]);
        end
        if (!b.last) return;
        for (int a = 0; a < 3; a++) begin
            p[a] = clamp_coord(ent_low[a] + clipped_move[a]);
        end
        r.new_x  = p[0][CW-1:0];
        r.new_y  = p[1][CW-1:0];
        r.new_z  = p[2][CW-1:0];
        r.stop_x = stop_bits[0];
        r.stop_y = stop_bits[1];
        r.stop_z = stop_bits[2];
        r.landed = landed_bit;
        resolved_q.push_back(r);
    endtask

    // Send one beat, with a random lead-in gap while sender idling is on; the mirror is updated at the accepting edge.
    task automatic send_beat(input t_beat b);
        int gap;
        @(negedge i_clk);
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = IN_W'(b.d);
        i_s_axis_tuser  = b.action;
        i_s_axis_tlast  = b.last;
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        resolve_beat(b);
        beats_sent++;
        if (b.action == ACT_START || b.d.solid || b.last) work_beats++;
    endtask

    // Stop sending and let every pending result come out, plus the block's own latency.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        size_q16[idx] = value[SIZE_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_sizes(input logic [APB_DATA_W-1:0] sx, input logic [APB_DATA_W-1:0] sy,
                             input logic [APB_DATA_W-1:0] sz);
        wait_idle();
        write_size(REG_SIZE_X, sx);
        write_size(REG_SIZE_Y, sy);
        write_size(REG_SIZE_Z, sz);
        size_settings++;
    endtask

    // Unused fields of a beat carry random bits, since the block must ignore them.
    function automatic t_beat start_beat(input longint cx, input longint cy, input longint cz,
                                         input longint mx, input longint my, input longint mz);
        t_beat b;
        b.action   = ACT_START;
        b.last     = 1'($urandom_range(0, 1));
        b.d.solid  = 1'($urandom_range(0, 1));
        b.d.coord_x = cx[CW-1:0];
        b.d.coord_y = cy[CW-1:0];
        b.d.coord_z = cz[CW-1:0];
        b.d.move_x  = mx[CW-1:0];
        b.d.move_y  = my[CW-1:0];
        b.d.move_z  = mz[CW-1:0];
        return b;
    endfunction

    function automatic t_beat voxel_beat(input longint cx, input longint cy, input longint cz,
                                         input logic solid, input logic last);
        t_beat b;
        b.action    = ACT_VOXEL;
        b.last      = last;
        b.d.solid   = solid;
        b.d.coord_x = cx[CW-1:0];
        b.d.coord_y = cy[CW-1:0];
        b.d.coord_z = cz[CW-1:0];
        b.d.move_x  = $urandom;
        b.d.move_y  = $urandom;
        b.d.move_z  = $urandom;
        return b;
    endfunction

    // A corner in or near a given grid square, occasionally anywhere in the range.
    function automatic longint near_cell(input int grid, input bit aligned_bias);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return sext($urandom);
        if (aligned_bias ? r < 17 : r < 6) return longint'(grid) * ONE;
        return longint'(grid) * ONE + longint'($urandom_range(0, 2*65536)) - 32768;
    endfunction

    function automatic longint rand_move();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 0;
        if (r < 9) begin
            if ($urandom_range(0, 1)) return longint'($urandom_range(1, 3*65536));
            return -longint'($urandom_range(1, 3*65536));
        end
        return sext($urandom);
    endfunction

    function automatic logic [APB_DATA_W-1:0] rand_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 32'd1048576;
        if (r == 2) return {$urandom} | 32'h001F_FFFF;
        if (r == 3) return $urandom;
        return $urandom_range(16384, 131072);
    endfunction

    // One entity: a start, voxels around its box, and a last voxel. Some sequences are
    // cut short, run on past the last voxel, or are replaced by a fully random beat.
    task automatic run_sequence();
        int    kind;
        int    n;
        int    grid[3];
        t_beat b;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            b        = voxel_beat(sext($urandom), sext($urandom), sext($urandom),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            b.action = t_action'($urandom_range(0, 1));
            send_beat(b);
            return;
        end
        for (int a = 0; a < 3; a++) grid[a] = $urandom_range(0, 8) - 4;
        send_beat(start_beat(near_cell(grid[0], 1'b0), near_cell(grid[1], 1'b0),
                             near_cell(grid[2], 1'b0), rand_move(), rand_move(), rand_move()));
        n = ($urandom_range(0, 9) == 0) ? 27 : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            send_beat(voxel_beat(near_cell(grid[0] + $urandom_range(0, 4) - 2, 1'b1),
                                 near_cell(grid[1] + $urandom_range(0, 4) - 2, 1'b1),
                                 near_cell(grid[2] + $urandom_range(0, 4) - 2, 1'b1),
                                 $urandom_range(0, 9) < 7, i == n - 1 && kind != 1));
        end
        if (kind == 2) begin
            // Voxels after the last one keep clipping the same entity.
            repeat ($urandom_range(1, 3)) begin
                send_beat(voxel_beat(near_cell(grid[0] + $urandom_range(0, 2) - 1, 1'b1),
                                     near_cell(grid[1] + $urandom_range(0, 2) - 1, 1'b1),
                                     near_cell(grid[2] + $urandom_range(0, 2) - 1, 1'b1),
                                     1'b1, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    // Voxels that arrive before any entity is loaded meet a zero box with no move.
    task automatic test_before_start();
        send_beat(voxel_beat(0, 0, 0, 1'b1, 1'b1));
        send_beat(voxel_beat(-ONE, -ONE, -ONE, 1'b0, 1'b1));
    endtask

    // Each axis clipped in both directions, landing, voxels past the last one and
    // the flag clear on a new start, all at the reset box size of 1.0.
    task automatic test_axis_clips();
        send_beat(start_beat(0, 2*ONE, 0, 3*ONE/2, -3*ONE/2, 3*ONE/2));
        send_beat(voxel_beat(2*ONE, 2*ONE, 0, 1'b1, 1'b0));
        send_beat(voxel_beat(0, 0, 0, 1'b1, 1'b0));
        send_beat(voxel_beat(0, 2*ONE, 2*ONE, 1'b1, 1'b1));
        send_beat(start_beat(5*ONE, 0, 5*ONE, -3*ONE/2, 3*ONE/2, -3*ONE/2));
        send_beat(voxel_beat(3*ONE, 0, 5*ONE, 1'b1, 1'b0));
        send_beat(voxel_beat(5*ONE, 2*ONE, 5*ONE, 1'b1, 1'b0));
        send_beat(voxel_beat(5*ONE, 0, 3*ONE, 1'b1, 1'b1));
        send_beat(voxel_beat(5*ONE, -ONE, 5*ONE, 1'b0, 1'b1));
        send_beat(start_beat(5*ONE, 0, 5*ONE, 0, 0, 0));
        send_beat(voxel_beat(5*ONE, 0, 5*ONE, 1'b1, 1'b1));
    endtask

    // Corners and moves at both ends of the range drive the output into saturation.
    task automatic test_range_extremes();
        send_beat(start_beat(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0));
        send_beat(voxel_beat(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1));
        send_beat(start_beat(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_beat(voxel_beat(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1));
    endtask

    // A size written after a start leaves the loaded box alone until the next start.
    task automatic test_size_mid_run();
        send_beat(start_beat(0, 0, 0, 3*ONE/2, 0, 0));
        set_sizes(2*ONE, ONE, ONE);
        send_beat(voxel_beat(2*ONE, 0, 0, 1'b1, 1'b1));
        send_beat(start_beat(0, 0, 0, 3*ONE/2, 0, 0));
        send_beat(voxel_beat(2*ONE, 0, 0, 1'b1, 1'b1));
    endtask

    // Empty boxes, boxes of 16.0, and junk above bit 20 over all-ones and all-zero registers.
    task automatic test_size_extremes();
        set_sizes(0, 0, 0);
        repeat (6) run_sequence();
        set_sizes(32'd1048576, 32'd1048576, 32'd1048576);
        repeat (6) run_sequence();
        set_sizes(32'hFFFF_FFFF, {$urandom} | 32'h001F_FFFF, 32'hA5E0_0000);
        repeat (6) run_sequence();
    endtask

    // Hold the sender back until every pending result has come out, then resume.
    task automatic test_pause_until_drained();
        repeat (4) run_sequence();
        wait_idle();
        repeat (4) run_sequence();
    endtask

    // Random phases, each with its own sizes and its own mix of idling on the two sides.
    task automatic test_random_sequences();
        int goal;
        int mode;
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal) begin
            set_sizes(rand_size(), rand_size(), rand_size());
            mode       = $urandom_range(0, 3);
            tx_idle_on = mode[0];
            rx_idle_on = mode[1];
            repeat ($urandom_range(10, 30)) run_sequence();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result side: random stalls, switched off in some phases.
    always @(negedge i_clk) begin
        if (rx_idle_on && stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = gap_len();
        end
        if (rx_idle_on && stall_left > 0) begin
            i_m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    // Every result beat must match the oldest resolved move still waiting.
    always @(posedge i_clk) begin
        t_move_result got;
        t_move_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_move_result)-1:0];
            results_seen++;
            if (resolved_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result %s", result_text(got)));
            end else begin
                want = resolved_q.pop_front();
                if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
                    got.new_z !== want.new_z || got.stop_x !== want.stop_x ||
                    got.stop_y !== want.stop_y || got.stop_z !== want.stop_z ||
                    got.landed !== want.landed) begin
                    note_mismatch($sformatf("expected %s, got %s",
                                            result_text(want), result_text(got)));
                end
            end
        end
    end

    initial begin
        int waited;
        t_move_result left;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_START;
        i_s_axis_tlast  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        reset_mirror();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_start();
        test_axis_clips();
        test_range_extremes();
        test_size_mid_run();
        test_size_extremes();
        test_pause_until_drained();
        test_random_sequences();

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        waited = 0;
        while (resolved_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (resolved_q.size() != 0) begin
            left = resolved_q.pop_front();
            note_mismatch($sformatf("result never came: %s", result_text(left)));
        end
        repeat (TAIL_CYCLES * 4) @(posedge i_clk);

        $display("Sent %0d beats (%0d doing work), checked %0d results over %0d size settings,",
                 beats_sent, work_beats, results_seen, size_settings);
        $display("with clips on every axis, range extremes and idling on both stream sides.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake; the slowest correct run is far shorter.
    initial begin
        #(12 * 1000000);
        $display("Run stopped by the timeout guard");
        $display("Mismatches found");
        $finish;
    end

endmodule
